FILE: rtl/core/lt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lt_pkg: shared types and constants of the log table bilinear interpolator
// Holds the opcode and register codes, the word passed from the front to the
// back end, and the table of tenth-power roots used by the mantissa stage.
// ----------------------------------------------------------------------------
package lt_pkg;

  localparam int LT_MAX_X_POINTS = 64;
  localparam int LT_MAX_Y_POINTS = 64;
  localparam int LT_FRAC_BITS    = 24;
  // Quotient of a cell fraction: a 32-bit magnitude scaled by 2^24.
  localparam int LT_DIV_BITS     = 56;
  // Width of the difference operands fed to the fraction multiplier.
  localparam int LT_MUL_BITS     = 48;
  localparam int LT_POW_BITS     = 35;

  localparam logic [63:0] LT_PROD_LIMIT = 64'd1 << 62;
  localparam logic [31:0] LT_MANT_MIN   = 32'd268435456;
  localparam logic [31:0] LT_MANT_MAX   = 32'd2684354559;

  localparam logic [1:0] LT_REG_X_POINTS = 2'd0;
  localparam logic [1:0] LT_REG_Y_POINTS = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD_X = 2'd0,
    OP_LOAD_Y = 2'd1,
    OP_LOAD_Z = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               ok;       // load index lies inside its table
    logic [11:0]        index;
    logic signed [31:0] value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic               last;
  } item_t;

  typedef logic [31:0] root_tab_t [LT_FRAC_BITS];

  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] rem;
    res   = '0;
    bit_v = 64'd1 << 62;
    rem   = n;
    for (int s = 0; s < 32; s++) begin
      if (bit_v > rem) bit_v = bit_v >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (bit_v != 0) begin
        if (rem >= res + bit_v) begin
          rem = rem - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // Entry i is ten to the power 2^-(i+1) in Q2.30, by repeated square roots.
  function automatic root_tab_t build_roots();
    root_tab_t   t;
    logic [63:0] r;
    r = 64'd10 << 30;
    for (int i = 0; i < LT_FRAC_BITS; i++) begin
      r    = isqrt64(r << 30);
      t[i] = r[31:0];
    end
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lt_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/lt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lt_front: input stage of the interpolator
// Takes words from the input stream, checks load indexes against the table
// sizes and queues the classified items for the back end.
// ----------------------------------------------------------------------------
module lt_front #(
  parameter int MAX_X_POINTS = lt_pkg::LT_MAX_X_POINTS,
  parameter int MAX_Y_POINTS = lt_pkg::LT_MAX_Y_POINTS
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire [111:0]         in_tdata,
  input  wire                 in_tlast,
  output lt_pkg::item_t       head,
  output logic                empty,
  input  wire                 pop
);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  lt_pkg::item_t     q_r [QDEPTH];
  logic [QAW-1:0]    wptr_r, wptr_nxt;
  logic [QAW-1:0]    rptr_r, rptr_nxt;
  logic [QAW:0]      cnt_r, cnt_nxt;
  lt_pkg::item_t     cls;
  logic              push;

  always_comb begin
    cls.op      = lt_pkg::op_t'(in_tdata[1:0]);
    cls.index   = in_tdata[13:2];
    cls.value   = in_tdata[45:14];
    cls.query_x = in_tdata[77:46];
    cls.query_y = in_tdata[109:78];
    cls.last    = in_tlast;
    unique case (cls.op)
      lt_pkg::OP_LOAD_X: cls.ok = 32'(cls.index) < 32'(MAX_X_POINTS);
      lt_pkg::OP_LOAD_Y: cls.ok = 32'(cls.index) < 32'(MAX_Y_POINTS);
      lt_pkg::OP_LOAD_Z: cls.ok = 32'(cls.index) < 32'(MAX_X_POINTS * MAX_Y_POINTS);
      default:           cls.ok = 1'b1;
    endcase
  end

  assign in_tready = cnt_r != (QAW+1)'(QDEPTH);
  assign push      = in_tvalid && in_tready;
  assign empty     = cnt_r == '0;
  assign head      = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) q_r[wptr_r] <= cls;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("queue holds more words than its depth");

endmodule
`default_nettype wire

FILE: rtl/core/lt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lt_back: execution stage of the interpolator
// Applies table loads and works through queries: cell search, cell fractions
// by a bit-serial divider, grid reads, bilinear blend by a serial multiplier
// and the power-of-ten mantissa.
// ----------------------------------------------------------------------------
module lt_back #(
  parameter int MAX_X_POINTS = lt_pkg::LT_MAX_X_POINTS,
  parameter int MAX_Y_POINTS = lt_pkg::LT_MAX_Y_POINTS
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire [$clog2(MAX_X_POINTS+1)-1:0]     nx,
  input  wire [$clog2(MAX_Y_POINTS+1)-1:0]     ny,
  input  wire lt_pkg::item_t                   head,
  input  wire                                  empty,
  output logic                                 pop,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [79:0]                          out_tdata,
  output logic                                 out_tlast
);

  localparam int XAW    = $clog2(MAX_X_POINTS);
  localparam int YAW    = $clog2(MAX_Y_POINTS);
  localparam int XCW    = $clog2(MAX_X_POINTS+1);
  localparam int YCW    = $clog2(MAX_Y_POINTS+1);
  localparam int GDEPTH = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int GAW    = $clog2(GDEPTH);
  localparam int DB     = lt_pkg::LT_DIV_BITS;
  localparam int MB     = lt_pkg::LT_MUL_BITS;
  localparam int PB     = lt_pkg::LT_POW_BITS;
  localparam int FB     = lt_pkg::LT_FRAC_BITS;
  localparam lt_pkg::root_tab_t ROOTS = lt_pkg::build_roots();
  localparam logic [63:0] SAT_LIM = lt_pkg::LT_PROD_LIMIT + 64'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRD, ST_SCMP, ST_C0, ST_C1, ST_C2, ST_DSET, ST_DIV,
    ST_GRD, ST_MSET, ST_MUL, ST_MFIN, ST_POW, ST_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic signed [31:0]    qx_r, qx_nxt, qy_r, qy_nxt;
  logic                  last_r, last_nxt;
  logic [XCW-1:0]        px_r, px_nxt;
  logic [YCW-1:0]        py_r, py_nxt;
  logic                  xdone_r, xdone_nxt, ydone_r, ydone_nxt;
  logic signed [31:0]    xlo_r, xlo_nxt, xhi_r, xhi_nxt;
  logic signed [31:0]    ylo_r, ylo_nxt, yhi_r, yhi_nxt;
  logic [GAW-1:0]        base_r, base_nxt;
  logic                  zw_r, zw_nxt;
  logic                  ax_r, ax_nxt;
  logic [31:0]           rem_r, rem_nxt;
  logic [DB-1:0]         quo_r, quo_nxt;
  logic [31:0]           dden_r, dden_nxt;
  logic                  dneg_r, dneg_nxt;
  logic [5:0]            cnt_r, cnt_nxt;
  logic signed [DB:0]    tx_r, tx_nxt, ty_r, ty_nxt;
  logic signed [31:0]    z_r [4];
  logic signed [31:0]    z_nxt [4];
  logic [1:0]            msel_r, msel_nxt;
  logic [MB-1:0]         up_r, up_nxt;
  logic [DB-1:0]         uq_r, uq_nxt;
  logic                  mneg_r, mneg_nxt;
  logic [63:0]           acc_r, acc_nxt;
  logic signed [MB-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic signed [31:0]    v_r, v_nxt;
  logic [PB-1:0]         pp_r, pp_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [79:0]           odata_r, odata_nxt;
  logic                  olast_r, olast_nxt;

  logic                  x_we, y_we, z_we;
  logic [XAW-1:0]        x_raddr;
  logic [YAW-1:0]        y_raddr;
  logic [GAW-1:0]        z_raddr;
  logic signed [31:0]    x_rd, y_rd, z_rd;

  logic [XAW-1:0]        j_idx;
  logic [YAW-1:0]        k_idx;
  logic                  x_cont, y_cont;
  logic signed [32:0]    num_s, den_s, mag_num, mag_den;
  logic [32:0]           dtrial;
  logic                  dge;
  logic [DB-1:0]         quo_step;
  logic signed [MB-1:0]  mp;
  logic signed [DB:0]    mq;
  logic [63:0]           msum;
  logic [63:0]           prod;
  logic signed [MB-1:0]  mres;
  logic signed [MB-1:0]  vsum;
  logic [PB+31:0]        pmul;
  logic [PB-1:0]         mant_w;
  logic [31:0]           mant;
  logic [GAW:0]          gsum;

  lt_ram #(.WIDTH(32), .DEPTH(MAX_X_POINTS)) u_xtab (
    .clk(clk), .we(x_we), .waddr(head.index[XAW-1:0]), .wdata(head.value),
    .raddr(x_raddr), .rdata(x_rd)
  );
  lt_ram #(.WIDTH(32), .DEPTH(MAX_Y_POINTS)) u_ytab (
    .clk(clk), .we(y_we), .waddr(head.index[YAW-1:0]), .wdata(head.value),
    .raddr(y_raddr), .rdata(y_rd)
  );
  lt_ram #(.WIDTH(32), .DEPTH(GDEPTH)) u_grid (
    .clk(clk), .we(z_we), .waddr(GAW'(head.index)), .wdata(head.value),
    .raddr(z_raddr), .rdata(z_rd)
  );

  assign pop   = (state_r == ST_IDLE) && !empty;
  assign x_we  = pop && head.op == lt_pkg::OP_LOAD_X && head.ok;
  assign y_we  = pop && head.op == lt_pkg::OP_LOAD_Y && head.ok;
  assign z_we  = pop && head.op == lt_pkg::OP_LOAD_Z && head.ok;

  // A search that never advanced still uses the first cell.
  assign j_idx = (px_r == '0) ? '0 : XAW'(px_r - 1'b1);
  assign k_idx = (py_r == '0) ? '0 : YAW'(py_r - 1'b1);

  always_comb begin
    x_raddr = XAW'(px_r);
    y_raddr = YAW'(py_r);
    if (state_r == ST_C0) begin
      x_raddr = j_idx;
      y_raddr = k_idx;
    end else if (state_r == ST_C1) begin
      x_raddr = j_idx + 1'b1;
      y_raddr = k_idx + 1'b1;
    end
  end

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    gsum = {1'b0, base_r};
      2'd1:    gsum = {1'b0, base_r} + 1'b1;
      2'd2:    gsum = {1'b0, base_r} + (GAW+1)'(ny);
      default: gsum = {1'b0, base_r} + (GAW+1)'(ny) + 1'b1;
    endcase
    z_raddr = gsum[GAW-1:0];
  end

  assign x_cont = !xdone_r && (px_r <= nx - 2'd2) && (qx_r >= x_rd);
  assign y_cont = !ydone_r && (py_r <= ny - 2'd2) && (qy_r >= y_rd);

  // Fraction operands of the axis in turn.
  always_comb begin
    if (ax_r) begin
      num_s = 33'(qy_r) - 33'(ylo_r);
      den_s = 33'(yhi_r) - 33'(ylo_r);
    end else begin
      num_s = 33'(qx_r) - 33'(xlo_r);
      den_s = 33'(xhi_r) - 33'(xlo_r);
    end
    mag_num = num_s[32] ? -num_s : num_s;
    mag_den = den_s[32] ? -den_s : den_s;
  end

  assign dtrial   = {rem_r, quo_r[DB-1]};
  assign dge      = dtrial >= {1'b0, dden_r};
  assign quo_step = {quo_r[DB-2:0], dge};

  always_comb begin
    case (msel_r)
      2'd0:    begin mp = MB'(z_r[1]) - MB'(z_r[0]); mq = ty_r; end
      2'd1:    begin mp = MB'(z_r[3]) - MB'(z_r[2]); mq = ty_r; end
      default: begin mp = b_r - a_r;                 mq = tx_r; end
    endcase
  end

  assign msum = {acc_r[62:0], 1'b0} + (up_r[MB-1] ? 64'(uq_r) : 64'd0);
  assign prod = (acc_r > lt_pkg::LT_PROD_LIMIT) ? lt_pkg::LT_PROD_LIMIT : acc_r;
  assign mres = mneg_r ? -MB'((prod + 64'hFFFFFF) >> FB) : MB'(prod >> FB);
  assign vsum = a_r + mres;

  assign pmul   = pp_r * ROOTS[cnt_r[4:0]];
  assign mant_w = (pp_r + 2'd2) >> 2;
  always_comb begin
    if (mant_w < PB'(lt_pkg::LT_MANT_MIN))      mant = lt_pkg::LT_MANT_MIN;
    else if (mant_w > PB'(lt_pkg::LT_MANT_MAX)) mant = lt_pkg::LT_MANT_MAX;
    else                                        mant = mant_w[31:0];
  end

  always_comb begin
    state_nxt  = state_r;
    qx_nxt     = qx_r;
    qy_nxt     = qy_r;
    last_nxt   = last_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    xdone_nxt  = xdone_r;
    ydone_nxt  = ydone_r;
    xlo_nxt    = xlo_r;
    xhi_nxt    = xhi_r;
    ylo_nxt    = ylo_r;
    yhi_nxt    = yhi_r;
    base_nxt   = base_r;
    zw_nxt     = zw_r;
    ax_nxt     = ax_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dden_nxt   = dden_r;
    dneg_nxt   = dneg_r;
    cnt_nxt    = cnt_r;
    tx_nxt     = tx_r;
    ty_nxt     = ty_r;
    z_nxt      = z_r;
    msel_nxt   = msel_r;
    up_nxt     = up_r;
    uq_nxt     = uq_r;
    mneg_nxt   = mneg_r;
    acc_nxt    = acc_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    v_nxt      = v_r;
    pp_nxt     = pp_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;

    unique case (state_r)
      ST_IDLE: begin
        if (pop && head.op == lt_pkg::OP_QUERY) begin
          qx_nxt    = head.query_x;
          qy_nxt    = head.query_y;
          last_nxt  = head.last;
          px_nxt    = '0;
          py_nxt    = '0;
          xdone_nxt = 1'b0;
          ydone_nxt = 1'b0;
          zw_nxt    = 1'b0;
          state_nxt = ST_SRD;
        end
      end
      ST_SRD: state_nxt = ST_SCMP;
      ST_SCMP: begin
        // Both axes are searched side by side, one abscissa per pass.
        if (x_cont) px_nxt = px_r + 1'b1;
        else        xdone_nxt = 1'b1;
        if (y_cont) py_nxt = py_r + 1'b1;
        else        ydone_nxt = 1'b1;
        state_nxt = (x_cont || y_cont) ? ST_SRD : ST_C0;
      end
      ST_C0: state_nxt = ST_C1;
      ST_C1: begin
        xlo_nxt   = x_rd;
        ylo_nxt   = y_rd;
        base_nxt  = GAW'(j_idx * ny + (GAW+1)'(k_idx));
        state_nxt = ST_C2;
      end
      ST_C2: begin
        xhi_nxt   = x_rd;
        yhi_nxt   = y_rd;
        ax_nxt    = 1'b0;
        state_nxt = ST_DSET;
      end
      ST_DSET: begin
        if (den_s == '0) begin
          zw_nxt = 1'b1;
          if (ax_r) begin
            ty_nxt    = '0;
            cnt_nxt   = '0;
            state_nxt = ST_GRD;
          end else begin
            tx_nxt = '0;
            ax_nxt = 1'b1;
          end
        end else begin
          dneg_nxt  = num_s[32] ^ den_s[32];
          quo_nxt   = {mag_num[31:0], {FB{1'b0}}};
          dden_nxt  = mag_den[31:0];
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = dge ? 32'(dtrial - {1'b0, dden_r}) : dtrial[31:0];
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'(DB - 1)) begin
          if (ax_r) begin
            ty_nxt    = dneg_r ? -(DB+1)'(quo_step) : (DB+1)'(quo_step);
            cnt_nxt   = '0;
            state_nxt = ST_GRD;
          end else begin
            tx_nxt    = dneg_r ? -(DB+1)'(quo_step) : (DB+1)'(quo_step);
            ax_nxt    = 1'b1;
            state_nxt = ST_DSET;
          end
        end
      end
      ST_GRD: begin
        // Corner read data arrives in the cycle after its address.
        if (cnt_r != '0) z_nxt = '{z_r[1], z_r[2], z_r[3], z_rd};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'd4) begin
          msel_nxt  = 2'd0;
          state_nxt = ST_MSET;
        end
      end
      ST_MSET: begin
        mneg_nxt  = mp[MB-1] ^ mq[DB];
        up_nxt    = mp[MB-1] ? -mp : mp;
        uq_nxt    = mq[DB] ? DB'(-mq) : DB'(mq);
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // Past the limit the exact value no longer matters, only that it is.
        acc_nxt = (msum > SAT_LIM) ? SAT_LIM : msum;
        up_nxt  = {up_r[MB-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'(MB - 1)) state_nxt = ST_MFIN;
      end
      ST_MFIN: begin
        msel_nxt = msel_r + 1'b1;
        case (msel_r)
          2'd0:    begin a_nxt = MB'(z_r[0]) + mres; state_nxt = ST_MSET; end
          2'd1:    begin b_nxt = MB'(z_r[2]) + mres; state_nxt = ST_MSET; end
          default: begin
            if (vsum > MB'(32'sh7FFFFFFF))       v_nxt = 32'sh7FFFFFFF;
            else if (vsum < -MB'(64'sh80000000)) v_nxt = 32'sh80000000;
            else                                 v_nxt = vsum[31:0];
            pp_nxt    = PB'(64'd1 << 30);
            cnt_nxt   = '0;
            state_nxt = ST_POW;
          end
        endcase
      end
      ST_POW: begin
        if (v_r[5'(FB - 1) - cnt_r[4:0]])
          pp_nxt = PB'((pmul + (PB+32)'(64'd1 << 29)) >> 30);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'(FB - 1)) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {7'd0, zw_r, v_r, mant, v_r[31:24]};
          olast_nxt  = last_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    qx_r    <= qx_nxt;
    qy_r    <= qy_nxt;
    last_r  <= last_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    xdone_r <= xdone_nxt;
    ydone_r <= ydone_nxt;
    xlo_r   <= xlo_nxt;
    xhi_r   <= xhi_nxt;
    ylo_r   <= ylo_nxt;
    yhi_r   <= yhi_nxt;
    base_r  <= base_nxt;
    zw_r    <= zw_nxt;
    ax_r    <= ax_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dden_r  <= dden_nxt;
    dneg_r  <= dneg_nxt;
    cnt_r   <= cnt_nxt;
    tx_r    <= tx_nxt;
    ty_r    <= ty_nxt;
    z_r     <= z_nxt;
    msel_r  <= msel_nxt;
    up_r    <= up_nxt;
    uq_r    <= uq_nxt;
    mneg_r  <= mneg_nxt;
    acc_r   <= acc_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    v_r     <= v_nxt;
    pp_r    <= pp_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && ovalid_r && !out_tready) |=> state_r == ST_OUT)
    else $error("result overwrote a word still waiting at the output");

  a_mant_range: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (odata_r[39:8] >= lt_pkg::LT_MANT_MIN &&
                  odata_r[39:8] <= lt_pkg::LT_MANT_MAX))
    else $error("mantissa outside one to ten");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCMP |-> (px_r < nx && py_r < ny))
    else $error("cell search ran past the abscissas in use");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !(x_we || y_we || z_we))
    else $error("table written while a query is in flight");

endmodule
`default_nettype wire

FILE: rtl/core/log_table_bilinear_interp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// log_table_bilinear_interp: bilinear interpolation over a log10 table
// Loads abscissa tables and a grid of log10 ordinates, then answers queries
// with the interpolated log value and ten to that power.
// ----------------------------------------------------------------------------
// Usage. Words on the input stream either load an entry (x abscissa, y
// abscissa or grid ordinate) or carry a query point. Loads give no result;
// each query gives one word on the output stream, with tlast copied from
// the query. The counts of abscissas in use are set through the cfg port,
// by the user only while the block is idle; the block does not enforce it.
// Operation. A load with an index inside its table is written when the back
// end takes it. A query goes through the cell search, one abscissa per pass,
// up to two 56-step divisions for the cell fractions, three 48-step serial
// multiplies for the blend and 24 steps of the root multiplier for the
// mantissa. Up to four words queue between the input and the back end, so
// loads and queries keep arriving while a query is worked on.
// Reset clears the queue, the result register and the counts (two each);
// table contents stay undefined until written. When the receiver stalls,
// the finished result is held, the next query is still worked through and
// waits in its last step until the output register is free.
// ----------------------------------------------------------------------------
module log_table_bilinear_interp #(
  parameter int MAX_X_POINTS = lt_pkg::LT_MAX_X_POINTS,
  parameter int MAX_Y_POINTS = lt_pkg::LT_MAX_Y_POINTS
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // opcode[1:0], index[13:2], value[45:14], query_x[77:46], query_y[109:78]
  input  wire [111:0]  in_tdata,
  input  wire          in_tlast,
  output logic         out_tvalid,
  input  wire          out_tready,
  // decade[7:0], mantissa[39:8], log_result[71:40], zero_width[72]
  output logic [79:0]  out_tdata,
  output logic         out_tlast,
  input  wire          cfg_we,
  input  wire [1:0]    cfg_index,
  input  wire [6:0]    cfg_wdata
);

  localparam int XCW = $clog2(MAX_X_POINTS+1);
  localparam int YCW = $clog2(MAX_Y_POINTS+1);

  logic [6:0]      xcfg_r, xcfg_nxt;
  logic [6:0]      ycfg_r, ycfg_nxt;
  logic [XCW-1:0]  nx;
  logic [YCW-1:0]  ny;
  lt_pkg::item_t   head;
  logic            empty;
  logic            pop;

  always_comb begin
    xcfg_nxt = xcfg_r;
    ycfg_nxt = ycfg_r;
    if (cfg_we) begin
      if (cfg_index == lt_pkg::LT_REG_X_POINTS) xcfg_nxt = cfg_wdata;
      if (cfg_index == lt_pkg::LT_REG_Y_POINTS) ycfg_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xcfg_r <= 7'd2;
      ycfg_r <= 7'd2;
    end else begin
      xcfg_r <= xcfg_nxt;
      ycfg_r <= ycfg_nxt;
    end
  end

  // Counts are used clamped to two and the table size.
  always_comb begin
    if (xcfg_r < 7'd2)                           nx = XCW'(2);
    else if (32'(xcfg_r) > 32'(MAX_X_POINTS))    nx = XCW'(MAX_X_POINTS);
    else                                         nx = XCW'(xcfg_r);
    if (ycfg_r < 7'd2)                           ny = YCW'(2);
    else if (32'(ycfg_r) > 32'(MAX_Y_POINTS))    ny = YCW'(MAX_Y_POINTS);
    else                                         ny = YCW'(ycfg_r);
  end

  lt_front #(.MAX_X_POINTS(MAX_X_POINTS), .MAX_Y_POINTS(MAX_Y_POINTS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .head(head), .empty(empty), .pop(pop)
  );

  lt_back #(.MAX_X_POINTS(MAX_X_POINTS), .MAX_Y_POINTS(MAX_Y_POINTS)) u_back (
    .clk(clk), .rst_n(rst_n), .nx(nx), .ny(ny),
    .head(head), .empty(empty), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

endmodule
`default_nettype wire

FILE: bench/tb_log_table_bilinear_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log_table_bilinear_interp: self-checking bench of the log table interpolator
// Loads abscissa tables and grids for a range of table sizes, sends random
// query points and compares every result word with an in-bench prediction of
// the cell search, the bilinear blend and the power-of-ten mantissa.
// ----------------------------------------------------------------------------
module tb_log_table_bilinear_interp;
  import lt_pkg::*;

  localparam int LIMIT_CYCLES = 6000000;
  localparam int DRAIN_CYCLES = 700;

  class interp_scoreboard;
    typedef struct {
      logic [7:0]  decade;
      logic [31:0] mant;
      logic [31:0] log_val;
      logic        zw;
      logic        lst;
    } result_t;

    result_t              awaited_q[$];
    longint               xs[LT_MAX_X_POINTS];
    longint               ys[LT_MAX_Y_POINTS];
    longint               zs[LT_MAX_X_POINTS * LT_MAX_Y_POINTS];
    int                   nx;
    int                   ny;
    longint unsigned      roots[LT_FRAC_BITS];
    int                   fails;
    int                   checked;

    function new();
      longint unsigned r;
      nx = 2;
      ny = 2;
      fails = 0;
      checked = 0;
      r = 64'd10 << 30;
      for (int i = 0; i < LT_FRAC_BITS; i++) begin
        r = int_sqrt(r << 30);
        roots[i] = r;
      end
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void set_count(logic [1:0] sel, logic [6:0] raw);
      int c;
      c = (raw < 2) ? 2 : (raw > 64) ? 64 : int'(raw);
      if (sel == LT_REG_X_POINTS) nx = c;
      else if (sel == LT_REG_Y_POINTS) ny = c;
    endfunction

    // Signed product scaled down by 2^24, floor rounding, magnitude capped.
    function longint scaled_mul(longint p, longint q);
      longint unsigned up;
      longint unsigned uq;
      longint unsigned prod;
      up = (p < 0) ? -p : p;
      uq = (q < 0) ? -q : q;
      if (up != 0 && uq > LT_PROD_LIMIT / up) prod = LT_PROD_LIMIT;
      else prod = up * uq;
      if ((p < 0) == (q < 0)) return longint'(prod >> 24);
      return -longint'((prod + 64'hFFFFFF) >> 24);
    endfunction

    function longint cell_frac(longint num, longint den, inout bit zw);
      if (den == 0) begin
        zw = 1;
        return 0;
      end
      return (num * 16777216) / den;
    endfunction

    function int find_cell(bit on_y, longint q);
      int j;
      int n;
      j = -1;
      n = on_y ? ny : nx;
      while (j < n - 2 && q >= (on_y ? ys[j + 1] : xs[j + 1])) j++;
      return (j < 0) ? 0 : j;
    endfunction

    function void note_word(op_t op, logic [11:0] idx, logic [31:0] val,
                            logic [31:0] qx_w, logic [31:0] qy_w, logic lst);
      longint qx, qy, tx, ty, a, b, v, frac, z11, z12, z21, z22;
      longint unsigned p, mant;
      int j, k;
      bit zw;
      result_t r;
      case (op)
        OP_LOAD_X: begin
          if (idx < LT_MAX_X_POINTS) xs[idx] = $signed(val);
        end
        OP_LOAD_Y: begin
          if (idx < LT_MAX_Y_POINTS) ys[idx] = $signed(val);
        end
        OP_LOAD_Z: begin
          zs[idx] = $signed(val);
        end
        default: begin
          zw = 0;
          qx = $signed(qx_w);
          qy = $signed(qy_w);
          j = find_cell(0, qx);
          k = find_cell(1, qy);
          tx = cell_frac(qx - xs[j], xs[j + 1] - xs[j], zw);
          ty = cell_frac(qy - ys[k], ys[k + 1] - ys[k], zw);
          z11 = zs[j * ny + k];
          z12 = zs[j * ny + k + 1];
          z21 = zs[(j + 1) * ny + k];
          z22 = zs[(j + 1) * ny + k + 1];
          a = z11 + scaled_mul(z12 - z11, ty);
          b = z21 + scaled_mul(z22 - z21, ty);
          v = a + scaled_mul(b - a, tx);
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
          frac = v & 64'hFFFFFF;
          p = 64'd1 << 30;
          for (int i = 0; i < LT_FRAC_BITS; i++) begin
            if ((frac >> (LT_FRAC_BITS - 1 - i)) & 1)
              p = (p * roots[i] + (64'd1 << 29)) >> 30;
          end
          mant = (p + 2) >> 2;
          if (mant < LT_MANT_MIN) mant = LT_MANT_MIN;
          if (mant > LT_MANT_MAX) mant = LT_MANT_MAX;
          r.decade = 8'((v - frac) / 16777216);
          r.mant = mant[31:0];
          r.log_val = v[31:0];
          r.zw = zw;
          r.lst = lst;
          awaited_q.push_back(r);
        end
      endcase
    endfunction

    function void check_word(logic [79:0] d, logic lst);
      result_t e;
      if (awaited_q.size() == 0) begin
        $error("result word with no query outstanding: %h", d);
        fails++;
        return;
      end
      e = awaited_q.pop_front();
      checked++;
      if (d[7:0] !== e.decade) begin
        $error("decade: expected %0d, got %0d", $signed(e.decade), $signed(d[7:0]));
        fails++;
      end
      if (d[39:8] !== e.mant) begin
        $error("mantissa: expected %h, got %h", e.mant, d[39:8]);
        fails++;
      end
      if (d[71:40] !== e.log_val) begin
        $error("log_result: expected %h, got %h", e.log_val, d[71:40]);
        fails++;
      end
      if (d[72] !== e.zw) begin
        $error("zero_width: expected %b, got %b", e.zw, d[72]);
        fails++;
      end
      if (lst !== e.lst) begin
        $error("last: expected %b, got %b", e.lst, lst);
        fails++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [79:0]  out_tdata;
  logic         out_tlast;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [6:0]   cfg_wdata;

  interp_scoreboard sb;
  bit               quiet;
  bit               hold_req;
  int               cycles;
  int               rand_words;
  int               queries;
  int               settings_run;

  log_table_bilinear_interp u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL log_table_bilinear_interp");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast);
  end

  // Result side: random stalls, and one long hold-off on request.
  initial begin
    int gap;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 0;
        repeat (2000) @(negedge clk);
        hold_req = 0;
      end
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_tready = 0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_word(op_t op, logic [11:0] idx, logic [31:0] val,
                           logic [31:0] qx, logic [31:0] qy, logic lst);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = {2'b00, qy, qx, val, idx, op};
    in_tlast = lst;
    in_tvalid = 1;
    do @(posedge clk); while (!in_tready);
    sb.note_word(op, idx, val, qx, qy, lst);
    if (op == OP_QUERY) queries++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] sel, logic [6:0] data);
    cfg_we = 1;
    cfg_index = sel;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 0;
    sb.set_count(sel, data);
  endtask

  // Waits for every outstanding result, then lets trailing loads finish.
  task automatic settle();
    in_tvalid = 0;
    while (sb.awaited_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] clip32(longint q);
    if (q > 64'sd2147483647) return 32'h7FFFFFFF;
    if (q < -64'sd2147483648) return 32'h80000000;
    return q[31:0];
  endfunction

  // mode 0: ascending, 1: ascending with repeats, 2: arbitrary values.
  task automatic load_axis(op_t op, int n, int mode);
    longint a;
    a = longint'($signed($urandom)) >>> 8;
    for (int i = 0; i < n; i++) begin
      if (mode == 2) a = $signed($urandom);
      else if (i > 0 && !(mode == 1 && $urandom_range(0, 3) == 0))
        a = a + $urandom_range(1, 1 << 20);
      send_word(op, 12'(i), clip32(a), $urandom, $urandom, 0);
    end
  endtask

  function automatic logic [31:0] grid_value(bit wide);
    if (wide) return $urandom;
    return $urandom_range(0, 32'd16 << 24) - (32'd8 << 24);
  endfunction

  function automatic logic [31:0] pick_coord(bit on_y);
    longint lo, hi, span;
    int n;
    n = on_y ? sb.ny : sb.nx;
    lo = on_y ? sb.ys[0] : sb.xs[0];
    hi = on_y ? sb.ys[n - 1] : sb.xs[n - 1];
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return on_y ? sb.ys[$urandom_range(0, n - 1)] : sb.xs[$urandom_range(0, n - 1)];
      default: begin
        if (hi < lo) begin
          span = lo;
          lo = hi;
          hi = span;
        end
        span = hi - lo;
        return clip32(lo - span / 4 + longint'($urandom) % (span * 3 / 2 + 1));
      end
    endcase
  endfunction

  task automatic run_setting(logic [6:0] xr, logic [6:0] yr, int nwords, bit squeeze);
    int mode;
    bit wide;
    op_t op;
    write_reg(LT_REG_X_POINTS, xr);
    write_reg(LT_REG_Y_POINTS, yr);
    settings_run++;
    quiet = ($urandom_range(0, 3) == 0);
    mode = $urandom_range(0, 5);
    mode = (mode < 3) ? 0 : mode - 3;
    wide = ($urandom_range(0, 4) == 0);
    load_axis(OP_LOAD_X, sb.nx, mode);
    load_axis(OP_LOAD_Y, sb.ny, mode);
    for (int i = 0; i < sb.nx * sb.ny; i++)
      send_word(OP_LOAD_Z, 12'(i), grid_value(wide), $urandom, $urandom, 0);
    rand_words += sb.nx + sb.ny + sb.nx * sb.ny;
    if (squeeze) hold_req = 1;
    for (int i = 0; i < nwords; i++) begin
      case ($urandom_range(0, 19))
        0: send_word(OP_LOAD_Z, 12'($urandom_range(0, sb.nx * sb.ny - 1)),
                     grid_value(wide), $urandom, $urandom, 0);
        1: send_word(OP_LOAD_X, 12'($urandom_range(0, sb.nx - 1)),
                     sb.xs[$urandom_range(0, sb.nx - 1)], $urandom, $urandom, 0);
        // Loads beyond the abscissa tables are dropped by the block.
        2: begin
          op = $urandom_range(0, 1) ? OP_LOAD_Y : OP_LOAD_X;
          send_word(op, 12'($urandom_range(64, 4095)), $urandom, $urandom, $urandom,
                    $urandom_range(0, 1));
        end
        default: send_word(OP_QUERY, 12'($urandom), $urandom, pick_coord(0),
                           pick_coord(1), $urandom_range(0, 3) == 0);
      endcase
      rand_words++;
    end
    settle();
  endtask

  initial begin
    logic [6:0] xr, yr;
    sb = new();
    cycles = 0;
    rand_words = 0;
    queries = 0;
    settings_run = 0;
    quiet = 0;
    hold_req = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    cfg_we = 0;
    cfg_index = LT_REG_X_POINTS;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: a 2 by 2 table, corners, extremes, saturation, a flat cell.
    write_reg(LT_REG_X_POINTS, 7'd2);
    write_reg(LT_REG_Y_POINTS, 7'd2);
    write_reg(2'd2, 7'h7F);
    write_reg(2'd3, 7'h55);
    send_word(OP_LOAD_X, 12'd0, -32'sd65536, 0, 0, 0);
    send_word(OP_LOAD_X, 12'd1, 32'sd65536, 0, 0, 0);
    send_word(OP_LOAD_Y, 12'd0, 32'sd0, 0, 0, 0);
    send_word(OP_LOAD_Y, 12'd1, 32'sd131072, 0, 0, 0);
    send_word(OP_LOAD_Z, 12'd0, 32'sd0, 0, 0, 0);
    send_word(OP_LOAD_Z, 12'd1, 32'sd16777216, 0, 0, 0);
    send_word(OP_LOAD_Z, 12'd2, 32'sd33554432, 0, 0, 0);
    send_word(OP_LOAD_Z, 12'd3, -32'sd50331648, 0, 0, 0);
    send_word(OP_QUERY, 12'hFFF, 32'hFFFFFFFF, 32'sd0, 32'sd65536, 0);
    send_word(OP_QUERY, 12'd0, 0, -32'sd65536, 32'sd0, 0);
    send_word(OP_QUERY, 12'd0, 0, 32'sd65536, 32'sd131072, 1);
    send_word(OP_QUERY, 12'd0, 0, 32'h80000000, 32'h80000000, 0);
    send_word(OP_QUERY, 12'd0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    send_word(OP_QUERY, 12'd0, 0, -32'sd70000, 32'sd131073, 1);
    send_word(OP_LOAD_Z, 12'd3, 32'h7FFFFFFF, 0, 0, 0);
    send_word(OP_QUERY, 12'd0, 0, 32'sd6553600, 32'sd6553600, 0);
    send_word(OP_LOAD_Z, 12'd3, 32'h80000000, 0, 0, 0);
    send_word(OP_QUERY, 12'd0, 0, 32'sd6553600, 32'sd6553600, 0);
    send_word(OP_LOAD_X, 12'd4095, 32'h12345678, 0, 0, 0);
    send_word(OP_LOAD_X, 12'd1, -32'sd65536, 0, 0, 0);
    send_word(OP_QUERY, 12'd0, 0, 32'sd100, 32'sd100, 1);
    send_word(OP_LOAD_Y, 12'd1, 32'sd0, 0, 0, 0);
    send_word(OP_QUERY, 12'd0, 0, -32'sd100, 32'sd5, 0);
    settle();

    // Extreme and out-of-range register values first, then random small tables.
    run_setting(7'd0, 7'd1, 60, 0);
    run_setting(7'd127, 7'd2, 80, 0);
    run_setting(7'd2, 7'd100, 80, 1);
    run_setting(7'd64, 7'd3, 60, 0);
    while (rand_words < 1800) begin
      xr = $urandom_range(2, 9);
      yr = $urandom_range(2, 9);
      run_setting(xr, yr, $urandom_range(60, 140), 0);
    end

    $display("Ran %0d table settings, %0d queries sent, %0d result words checked.",
             settings_run, queries, sb.checked);
    if (sb.fails == 0 && sb.awaited_q.size() == 0) begin
      $display("PASS log_table_bilinear_interp");
    end else begin
      $display("FAIL log_table_bilinear_interp");
    end
    $finish;
  end

endmodule
